[rtl/core/gst_pkg.sv]
// Shared types and constants for the group soft-threshold unit
package gst_pkg;
    localparam int DATA_W = 24;
    localparam int SUM_W  = 53;
    localparam int ROOT_W = 27;
    localparam int PROD_W = 51;

    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic             overflow;
    } seg_info_t;
endpackage

[rtl/core/group_soft_threshold_unit.sv]
// Top level of the group soft-threshold unit
//  channel  | handshake                 | payload
//  input    | sample_valid/sample_stall | sample, segment_end
//  output   | out_valid/out_stall       | shrunk, run_end, overflowed
//  config   | threshold_we              | threshold_wdata
// Elements load at one per cycle while the back end is idle; a closing element holds
// the input until the back end takes the segment, and the input stays held until the
// back end has emitted the whole run.
// Back end: per segment an accept step and a bit-serial square root, then per result
// a read, a multiply, a bit-serial divide and an output step that waits while
// out_stall is high.
// Reset clears control state; buffer contents are undefined until written.
module group_soft_threshold_unit
    import gst_pkg::*;
#(
    parameter int MAX_GROUP = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     threshold_we,
    input  logic [DATA_W-1:0]        threshold_wdata,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     segment_end,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] shrunk,
    output logic                     run_end,
    output logic                     overflowed
);
    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    logic [DATA_W-1:0] threshold_reg;
    logic              wr_en, seg_valid, seg_stall;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] rd_data;
    seg_info_t         seg_info;
    logic [CNT_W-1:0]  seg_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (threshold_we)
        begin
            threshold_reg <= threshold_wdata;
        end
    end

    gst_front #(.MAX_GROUP(MAX_GROUP), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_front (
        .clk(clk), .rst_n(rst_n), .sample_valid(sample_valid),
        .sample_stall(sample_stall), .sample(sample), .segment_end(segment_end),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .seg_valid(seg_valid), .seg_stall(seg_stall), .seg_info(seg_info),
        .seg_count(seg_count)
    );

    gst_store #(.DEPTH(MAX_GROUP), .IDX_W(IDX_W)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    gst_back #(.CNT_W(CNT_W), .IDX_W(IDX_W)) u_back (
        .clk(clk), .rst_n(rst_n), .threshold(threshold_reg),
        .seg_valid(seg_valid), .seg_stall(seg_stall), .seg_info(seg_info),
        .seg_count(seg_count), .rd_addr(rd_addr), .rd_data(rd_data),
        .out_valid(out_valid), .out_stall(out_stall), .shrunk(shrunk),
        .run_end(run_end), .overflowed(overflowed)
    );
endmodule

[rtl/core/gst_front.sv]
// Front end: buffer a segment and accumulate its sum of squares
module gst_front
    import gst_pkg::*;
#(
    parameter int MAX_GROUP = 32,
    parameter int CNT_W = 6,
    parameter int IDX_W = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                    segment_end,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output logic [DATA_W-1:0]       wr_data,
    output logic                    seg_valid,
    input  logic                    seg_stall,
    output seg_info_t               seg_info,
    output logic [CNT_W-1:0]        seg_count
);
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic             pend_reg, pend_next;
    logic             acc;
    logic             room;
    logic signed [2*DATA_W-1:0] sq;

    assign sample_stall = pend_reg || seg_stall;
    assign acc  = sample_valid && !sample_stall;
    assign room = fill_reg < CNT_W'(MAX_GROUP);
    assign sq   = sample * sample;
    assign wr_en   = acc && room;
    assign wr_addr = fill_reg[IDX_W-1:0];
    assign wr_data = sample;
    assign seg_valid = pend_reg;
    assign seg_info.square_sum = sum_reg;
    assign seg_info.overflow   = ovf_reg;
    assign seg_count = fill_reg;

    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        pend_next = pend_reg;
        if (pend_reg && !seg_stall)
        begin
            sum_next  = '0;
            fill_next = '0;
            ovf_next  = 1'b0;
            pend_next = 1'b0;
        end
        if (acc)
        begin
            if (room)
            begin
                sum_next  = sum_reg + SUM_W'(unsigned'(sq));
                fill_next = fill_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            pend_next = segment_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            pend_reg <= pend_next;
        end
    end
endmodule

[rtl/core/gst_back.sv]
// Back end: root, divide and emit the scaled segment
module gst_back
    import gst_pkg::*;
#(
    parameter int CNT_W = 6,
    parameter int IDX_W = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [DATA_W-1:0]        threshold,
    input  logic                     seg_valid,
    output logic                     seg_stall,
    input  seg_info_t                seg_info,
    input  logic [CNT_W-1:0]         seg_count,
    output logic [IDX_W-1:0]         rd_addr,
    input  logic signed [DATA_W-1:0] rd_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DATA_W-1:0]        shrunk,
    output logic                     run_end,
    output logic                     overflowed
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [2:0]        state_reg, state_next;
    logic [SUM_W:0]    rem_reg, rem_next;
    logic [SUM_W:0]    sum_reg, sum_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, idx_reg, idx_next;
    logic              ovf_reg, ovf_next, pass_reg, pass_next;
    logic [ROOT_W-1:0] keep_reg, keep_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [ROOT_W:0]   drem_reg, drem_next;
    logic [DATA_W-1:0] shr_reg, shr_next;
    logic              end_reg, end_next;

    logic [SUM_W+1:0]  trial;
    logic [ROOT_W:0]   dtrial;
    logic [DATA_W-1:0] mag;
    logic [2*DATA_W-1:0] thr_sq;

    assign seg_stall  = state_reg != S_IDLE;
    assign rd_addr    = idx_reg[IDX_W-1:0];
    assign out_valid  = state_reg == S_OUT;
    assign shrunk     = shr_reg;
    assign run_end    = end_reg;
    assign overflowed = ovf_reg;
    assign thr_sq     = threshold * threshold;
    assign mag        = rd_data[DATA_W-1] ? DATA_W'(-rd_data) : DATA_W'(rd_data);

    always_comb
    begin
        state_next = state_reg;
        rem_next = rem_reg; sum_next = sum_reg; root_next = root_reg;
        step_next = step_reg; cnt_next = cnt_reg; idx_next = idx_reg;
        ovf_next = ovf_reg; pass_next = pass_reg; keep_next = keep_reg;
        neg_next = neg_reg; quo_next = quo_reg; drem_next = drem_reg;
        shr_next = shr_reg; end_next = end_reg;
        trial  = '0;
        dtrial = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (seg_valid)
                begin
                    sum_next  = {1'b0, seg_info.square_sum};
                    rem_next  = '0;
                    root_next = '0;
                    ovf_next  = seg_info.overflow;
                    cnt_next  = seg_count;
                    idx_next  = '0;
                    pass_next = seg_info.square_sum > SUM_W'(thr_sq);
                    step_next = STEP_W'(ROOT_W);
                    state_next = (seg_count == '0) ? S_IDLE : S_ROOT;
                end
            end
            S_ROOT:
            begin
                rem_next = {rem_reg[SUM_W-2:0], sum_reg[SUM_W:SUM_W-1]};
                sum_next = {sum_reg[SUM_W-2:0], 2'b00};
                trial = {rem_reg[SUM_W-1:0], sum_reg[SUM_W:SUM_W-1]}
                        - {(SUM_W+2-ROOT_W-2)'(0), root_reg, 2'b01};
                if (!trial[SUM_W+1])
                begin
                    rem_next  = trial[SUM_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                keep_next  = root_reg - ROOT_W'(threshold);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                neg_next  = rd_data[DATA_W-1];
                quo_next  = PROD_W'(mag) * PROD_W'(keep_reg);
                drem_next = '0;
                step_next = STEP_W'(PROD_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dtrial = {drem_reg[ROOT_W-1:0], quo_reg[PROD_W-1]} - {1'b0, root_reg};
                quo_next = {quo_reg[PROD_W-2:0], !dtrial[ROOT_W]};
                drem_next = dtrial[ROOT_W] ? {drem_reg[ROOT_W-1:0], quo_reg[PROD_W-1]}
                                           : dtrial;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = (idx_reg + CNT_W'(1) == cnt_reg) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_DIV && step_reg == STEP_W'(1))
        begin
            if (!pass_reg || root_reg == '0)
            begin
                shr_next = '0;
            end
            else
            begin
                shr_next = neg_reg ? DATA_W'(-quo_next[DATA_W-1:0])
                                   : quo_next[DATA_W-1:0];
            end
            end_next = idx_reg + CNT_W'(1) == cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next; sum_reg <= sum_next; root_reg <= root_next;
        ovf_reg <= ovf_next; pass_reg <= pass_next; keep_reg <= keep_next;
        neg_reg <= neg_next; quo_reg <= quo_next; drem_reg <= drem_next;
        shr_reg <= shr_next; end_reg <= end_next;
    end
endmodule

[rtl/core/gst_store.sv]
// Segment buffer memory, registered read
module gst_store
    import gst_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[tb/tb_group_soft_threshold_unit.sv]
// Testbench for the group soft-threshold unit: directed table, random segments, predictor check
`timescale 1ns / 100ps

module tb_group_soft_threshold_unit;
    import gst_pkg::*;

    localparam int GROUP_DEPTH = 32;
    localparam int LIMIT       = 3000000;
    localparam int SETTLE      = 3000;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     has_ref;
        logic signed [DATA_W-1:0] ref_value;
    } stim_row_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     over;
    } shrink_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     threshold_we;
    logic [DATA_W-1:0]        threshold_wdata;
    logic                     sample_valid;
    logic                     sample_stall;
    logic signed [DATA_W-1:0] sample;
    logic                     segment_end;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] shrunk;
    logic                     run_end;
    logic                     overflowed;

    logic [DATA_W-1:0]        lambda;
    logic signed [DATA_W-1:0] held_values[GROUP_DEPTH];
    int                       held_count;
    logic [SUM_W-1:0]         energy;
    logic                     dropped;
    shrink_result_t           pending_results[$];
    logic                     stim_done;
    logic                     long_hold;
    int                       errors;
    int                       cycles;

    group_soft_threshold_unit #(.MAX_GROUP(GROUP_DEPTH)) i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic absorb_sample(input logic signed [DATA_W-1:0] x, input logic last);
        logic signed [63:0] wide;
        logic [63:0]        norm;
        logic [63:0]        keep;
        logic [63:0]        mag;
        logic               pass;
        shrink_result_t     res;
        wide = x;
        if (held_count < GROUP_DEPTH)
        begin
            held_values[held_count] = x;
            held_count++;
            energy = energy + SUM_W'(wide * wide);
        end
        else
            dropped = 1'b1;
        if (!last) return;
        pass = {11'd0, energy} > 64'(lambda) * 64'(lambda);
        norm = pass ? isqrt({11'd0, energy}) : 64'd0;
        keep = norm - 64'(lambda);
        for (int k = 0; k < held_count; k++)
        begin
            wide = held_values[k];
            res.value = '0;
            if (pass && norm != 0)
            begin
                mag = wide < 0 ? -wide : wide;
                mag = (mag * keep) / norm;
                res.value = wide < 0 ? -DATA_W'(mag) : DATA_W'(mag);
            end
            res.last = (k + 1 == held_count);
            res.over = dropped;
            pending_results.push_back(res);
        end
        held_count = 0;
        energy     = '0;
        dropped    = 1'b0;
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] x, input logic last,
                               input logic has_ref = 1'b0,
                               input logic signed [DATA_W-1:0] ref_value = '0);
        sample_valid <= 1'b1;
        sample       <= x;
        segment_end  <= last;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        absorb_sample(x, last);
        if (has_ref && last && pending_results.size() != 0)
        begin
            if (pending_results[pending_results.size() - 1].value !== ref_value)
            begin
                $error("shrunk: expected %0d, actual %0d", ref_value,
                       pending_results[pending_results.size() - 1].value);
                errors++;
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                              : $urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic write_lambda(input logic [DATA_W-1:0] value);
        sample_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        threshold_we    <= 1'b1;
        threshold_wdata <= value;
        @(posedge clk);
        threshold_we <= 1'b0;
        lambda       = value;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample(input int mode);
        case (mode)
            0: return DATA_W'($urandom);
            1: return DATA_W'($signed($urandom_range(0, 2 ** 17)) - 2 ** 16);
            default: return DATA_W'($signed($urandom_range(0, 2 ** 9)) - 2 ** 8);
        endcase
    endfunction

    stim_row_t directed[8] = '{
        '{24'sh7FFFFF, 1'b1, 1'b1, 24'sh7FFFFF},
        '{24'sh800000, 1'b1, 1'b1, 24'sh800000},
        '{24'sh000000, 1'b1, 1'b1, 24'sh000000},
        '{24'sh000001, 1'b0, 1'b0, 24'sh000000},
        '{24'shFFFFFF, 1'b1, 1'b0, 24'sh000000},
        '{24'sh010000, 1'b0, 1'b0, 24'sh000000},
        '{24'sh123456, 1'b0, 1'b0, 24'sh000000},
        '{24'shABCDEF, 1'b1, 1'b0, 24'sh000000}
    };

    initial
    begin
        rst_n           = 1'b0;
        threshold_we    = 1'b0;
        threshold_wdata = '0;
        sample_valid    = 1'b0;
        sample          = '0;
        segment_end     = 1'b0;
        stim_done       = 1'b0;
        long_hold       = 1'b0;
        lambda          = '0;
        held_count      = 0;
        energy          = '0;
        dropped         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_sample(directed[i].value, directed[i].last, directed[i].has_ref,
                        directed[i].ref_value);
        write_lambda(24'hFFFFFF);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh800000, 1'b1);
        write_lambda(24'h010000);
        long_hold <= 1'b1;
        send_sample(24'sh010000, 1'b1);
        for (int i = 0; i < 34; i++) send_sample(DATA_W'(i * 4099), i == 33);
        for (int phase = 0; phase < 5; phase++)
        begin
            write_lambda(phase == 0 ? 24'h000000 : phase == 4 ? 24'hFFFFFF
                                                             : DATA_W'($urandom_range(0, 2 ** 19)));
            for (int s = 0; s < 7; s++)
            begin
                int len;
                int mode;
                len  = $urandom_range(0, 9) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 6);
                mode = $urandom_range(0, 2);
                for (int k = 0; k < len; k++) send_sample(rand_sample(mode), k == len - 1);
            end
        end
        sample_valid <= 1'b0;
        stim_done    <= 1'b1;
    end

    initial
    begin
        out_stall = 1'b0;
        wait (long_hold);
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        forever
        begin
            out_stall <= ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 19) == 0 ? $urandom_range(8, 40)
                                               : $urandom_range(1, 4)) @(posedge clk);
            if ($urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b0;
                repeat (60) @(posedge clk);
            end
        end
    end

    initial
    begin
        shrink_result_t want;
        errors = 0;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (out_valid && !out_stall && rst_n)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected transaction: shrunk=%0d", shrunk);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (shrunk !== want.value)
                    begin
                        $error("shrunk: expected %0d, actual %0d", want.value, shrunk);
                        errors++;
                    end
                    if (run_end !== want.last)
                    begin
                        $error("run_end: expected %0d, actual %0d", want.last, run_end);
                        errors++;
                    end
                    if (overflowed !== want.over)
                    begin
                        $error("overflowed: expected %0d, actual %0d", want.over, overflowed);
                        errors++;
                    end
                end
            end
            if (cycles >= LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
